// ===== design/wrr_pkg.sv =====
// Shared types, constants and controller encodings for the weighted random router.
`default_nettype none
package wrr_pkg;

    localparam int MAX_RECEIVERS_DEF = 16;

    // Probabilities are unsigned Q1.16, so one is 2^16.
    localparam logic [16:0] Q_ONE      = 17'd65536;
    localparam logic [6:0]  DRAW_SCALE = 7'd100;
    localparam logic [4:0]  DIV_STEPS  = 5'd17;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_ROUTE  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ONE   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_DIV,
        S_ADD_SETUP,
        S_ADD_MUL,
        S_ADD_WB,
        S_ADD_WRITE,
        S_REM_CHECK,
        S_REM_START,
        S_REM_DIV,
        S_RT_ADD,
        S_RT_CMP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [16:0] link_probability;
        logic        use_even_share;
        logic [6:0]  random_draw;
    } t_in_item;

    typedef struct packed {
        logic [3:0] chosen_index;
        logic       picked;
        logic [4:0] link_count;
        logic [1:0] status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    idx_clr;
        logic    idx_inc;
        logic    idx_load_last;
        logic    count_inc;
        logic    count_dec;
        logic    p_from_in;
        logic    p_from_div;
        logic    keep_load;
        logic    prod_load;
        logic    tab_wr_scaled;
        logic    tab_wr_new;
        logic    tab_wr_div;
        logic    rest_load;
        logic    sum_clr;
        logic    sum_add;
        logic    div_start;
        logic    div_even;
        logic    set_status;
        t_status status_code;
        logic    set_pick;
        logic    load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic count_zero;
        logic count_full;
        logic prob_even;
        logic idx_last;
        logic rd_one;
        logic div_done;
        logic hit;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/wrr_div.sv =====
// Radix-2 restoring divider producing a Q1.16 quotient saturated at one.
`default_nettype none
module wrr_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [32:0] i_dividend,
    input  wire logic [16:0] i_divisor,
    output logic             o_done,
    output logic [16:0]      o_quotient
);
    import wrr_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [16:0] r_rem;
    logic [16:0] r_low;
    logic [16:0] r_q;
    logic [16:0] r_div;

    logic [17:0] trial;
    logic        geq;
    logic [16:0] n_rem;

    assign trial = {r_rem, r_low[16]};
    assign geq   = trial >= {1'b0, r_div};
    assign n_rem = geq ? 17'(trial - {1'b0, r_div}) : trial[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_div <= i_divisor;
                // A quotient of 2^17 or more is far above one, so it saturates at once.
                if ({1'b0, i_dividend[32:17]} >= i_divisor) begin
                    r_q    <= Q_ONE;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem  <= {1'b0, i_dividend[32:17]};
                    r_low  <= i_dividend[16:0];
                    r_q    <= '0;
                    r_cnt  <= DIV_STEPS;
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_low  <= {r_low[15:0], 1'b0};
                r_q    <= {r_q[15:0], geq};
                r_cnt  <= r_cnt - 5'd1;
                r_done <= (r_cnt == 5'd1);
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = (r_q > Q_ONE) ? Q_ONE : r_q;

endmodule
`default_nettype wire

// ===== design/wrr_datapath.sv =====
// Datapath: probability table memory, multiplier, divider, running sum and result register.
`default_nettype none
module wrr_datapath #(
    parameter int MAX_RECEIVERS = wrr_pkg::MAX_RECEIVERS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire wrr_pkg::t_in_item i_in_data,
    input  wire wrr_pkg::t_cmd    i_cmd,
    output wrr_pkg::t_stat        o_stat,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output wrr_pkg::t_out_item    o_out_data
);
    import wrr_pkg::*;

    localparam int IW = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1;
    localparam int CW = $clog2(MAX_RECEIVERS + 1);

    logic [16:0] mem [MAX_RECEIVERS];

    logic [1:0]    r_op;
    logic [16:0]   r_prob;
    logic          r_even;
    logic [6:0]    r_draw;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic [16:0]   r_rd;
    logic [16:0]   r_p;
    logic [16:0]   r_keep;
    logic [33:0]   r_prod;
    logic [16:0]   r_rest;
    logic [16:0]   r_sum;
    t_status       r_status;
    logic          r_picked;
    logic [3:0]    r_chosen;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          div_done;
    logic [16:0]   div_q;
    logic [32:0]   div_dividend;
    logic [16:0]   div_divisor;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [16:0]   wr_data;
    logic [16:0]   scaled;
    logic [17:0]   sum_wide;
    logic [16:0]   sum_sat;
    logic [23:0]   draw_scaled;
    logic [23:0]   sum_scaled;

    always_comb begin
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_load_last) begin
            n_idx = IW'(r_count - CW'(1));
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + IW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    assign scaled   = (r_prod[33:16] > {1'b0, Q_ONE}) ? Q_ONE : r_prod[32:16];
    assign sum_wide = {1'b0, r_sum} + {1'b0, r_rd};
    assign sum_sat  = (sum_wide > {1'b0, Q_ONE}) ? Q_ONE : sum_wide[16:0];

    // The draw is compared in Q.16 against the running sum scaled by the draw range.
    assign draw_scaled = {1'b0, r_draw, 16'd0};
    assign sum_scaled  = 24'(r_sum) * 24'(DRAW_SCALE);

    always_comb begin
        wr_en   = i_cmd.tab_wr_scaled | i_cmd.tab_wr_new | i_cmd.tab_wr_div;
        wr_addr = r_idx;
        wr_data = scaled;
        if (i_cmd.tab_wr_new) begin
            wr_addr = IW'(r_count);
            wr_data = r_p;
        end else if (i_cmd.tab_wr_div) begin
            wr_data = div_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[n_idx];
    end

    assign div_dividend = i_cmd.div_even ? 33'(Q_ONE) : {r_rd, 16'd0};
    assign div_divisor  = i_cmd.div_even ? (17'(r_count) + 17'd1) : r_rest;

    wrr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.count_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_in_data.operation;
            r_prob   <= i_in_data.link_probability;
            r_even   <= i_in_data.use_even_share;
            r_draw   <= i_in_data.random_draw;
            r_status <= ST_OK;
            r_picked <= 1'b0;
            r_chosen <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status_code;
            end
            if (i_cmd.set_pick) begin
                r_picked <= 1'b1;
                r_chosen <= 4'(r_idx);
            end
        end
        if (i_cmd.p_from_in) begin
            r_p <= r_prob;
        end else if (i_cmd.p_from_div) begin
            r_p <= div_q;
        end
        if (i_cmd.keep_load) begin
            r_keep <= Q_ONE - r_p;
        end
        if (i_cmd.prod_load) begin
            r_prod <= r_rd * r_keep;
        end
        if (i_cmd.rest_load) begin
            r_rest <= Q_ONE - r_rd;
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sum_add) begin
            r_sum <= sum_sat;
        end
        if (i_cmd.load_out) begin
            r_out.chosen_index <= r_chosen;
            r_out.picked       <= r_picked;
            r_out.link_count   <= 5'(r_count);
            r_out.status       <= r_status;
        end
    end

    always_comb begin
        o_stat.op         = t_op'(r_op);
        o_stat.count_zero = (r_count == '0);
        o_stat.count_full = (r_count == CW'(MAX_RECEIVERS));
        o_stat.prob_even  = r_even || (r_prob > Q_ONE);
        o_stat.idx_last   = ((CW'(r_idx) + CW'(1)) == r_count);
        o_stat.rd_one     = (r_rd >= Q_ONE);
        o_stat.div_done   = div_done;
        o_stat.hit        = (draw_scaled <= sum_scaled);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== design/wrr_ctrl.sv =====
// Controller state machine sequencing add, remove and route over the datapath.
`default_nettype none
module wrr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire wrr_pkg::t_stat i_stat,
    output wrr_pkg::t_cmd      o_cmd
);
    import wrr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.status_code = ST_OK;
        o_in_ready        = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op)
                    OP_ADD: begin
                        if (i_stat.count_full) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_FULL;
                            n_state           = S_FINISH;
                        end else if (i_stat.prob_even) begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_even  = 1'b1;
                            n_state         = S_ADD_DIV;
                        end else begin
                            o_cmd.p_from_in = 1'b1;
                            n_state         = S_ADD_SETUP;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.count_zero) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_EMPTY;
                            n_state           = S_FINISH;
                        end else begin
                            o_cmd.count_dec     = 1'b1;
                            o_cmd.idx_load_last = 1'b1;
                            n_state             = S_REM_CHECK;
                        end
                    end
                    OP_ROUTE: begin
                        if (i_stat.count_zero) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_EMPTY;
                            n_state           = S_FINISH;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            o_cmd.sum_clr = 1'b1;
                            n_state       = S_RT_ADD;
                        end
                    end
                    OP_NOP: begin
                        n_state = S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_ADD_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.p_from_div = 1'b1;
                    n_state          = S_ADD_SETUP;
                end
            end
            S_ADD_SETUP: begin
                o_cmd.keep_load = 1'b1;
                o_cmd.idx_clr   = 1'b1;
                n_state         = i_stat.count_zero ? S_ADD_WRITE : S_ADD_MUL;
            end
            S_ADD_MUL: begin
                o_cmd.prod_load = 1'b1;
                n_state         = S_ADD_WB;
            end
            S_ADD_WB: begin
                o_cmd.tab_wr_scaled = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_ADD_WRITE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_ADD_MUL;
                end
            end
            S_ADD_WRITE: begin
                o_cmd.tab_wr_new = 1'b1;
                o_cmd.count_inc  = 1'b1;
                n_state          = S_FINISH;
            end
            S_REM_CHECK: begin
                // A removed share of one leaves nothing to renormalize by.
                if (i_stat.rd_one) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_ONE;
                    n_state           = S_FINISH;
                end else begin
                    o_cmd.rest_load = 1'b1;
                    if (i_stat.count_zero) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_REM_START;
                    end
                end
            end
            S_REM_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_REM_DIV;
            end
            S_REM_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.tab_wr_div = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_REM_START;
                    end
                end
            end
            S_RT_ADD: begin
                o_cmd.sum_add = 1'b1;
                n_state       = S_RT_CMP;
            end
            S_RT_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.set_pick = 1'b1;
                    n_state        = S_FINISH;
                end else if (i_stat.idx_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RT_ADD;
                end
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/weighted_random_router_core.sv =====
// Top level of the weighted random router: controller plus datapath.
//
// Roulette-wheel router over a table of up to MAX_RECEIVERS Q1.16 probabilities.
// One transaction is taken at a time and gives exactly one result transaction.
// With N receivers in the table, a route walks the entries in order until the
// draw falls within the running sum or the last entry is done; an add rescales
// the N entries, first computing the even share in the divider when that share
// is used; a remove sends each remaining entry through the one-bit-per-cycle
// divider, which sets the cost of that operation. Table reads go through one
// registered memory port. The result register lets the next transaction start
// while an earlier result still waits downstream. The table needs no clearing
// after reset: only entries below the receiver count are ever read.
`default_nettype none
module weighted_random_router_core #(
    parameter int MAX_RECEIVERS = wrr_pkg::MAX_RECEIVERS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire wrr_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output wrr_pkg::t_out_item     o_out_data
);
    import wrr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    wrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wrr_datapath #(
        .MAX_RECEIVERS (MAX_RECEIVERS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== tb/weighted_random_router_core_tb.sv =====
// Self-checking testbench for the weighted random router core.
`default_nettype none
module weighted_random_router_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wrr_pkg::*;

    localparam int MAX_RX       = MAX_RECEIVERS_DEF;
    localparam int RANDOM_ITEMS = 1900;
    localparam int STALL_LIMIT  = 3000;

    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_pending;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Predicted table state.
    logic [16:0] rx_prob [MAX_RX];
    logic [4:0]  rx_count;

    t_pending  pending_items[$];
    t_out_item expected_results[$];
    t_out_item want;
    int        n_items     = 0;
    int        gen_count   = 0;
    int        errors      = 0;
    int        in_flight   = 0;
    int        accepted_in = 0;
    int        idle_cycles = 0;
    int        sent        = 0;
    int        taken       = 0;
    int        hold_left   = 0;
    bit        held        = 1'b0;

    weighted_random_router_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [16:0] clip_one(input logic [33:0] v);
        return (v > 34'(Q_ONE)) ? Q_ONE : v[16:0];
    endfunction

    // Applies one transaction to the predicted table and returns its result.
    function automatic t_out_item predict_router(input t_in_item it);
        t_out_item   res;
        logic [16:0] share;
        logic [16:0] keep;
        logic [16:0] gone;
        logic [16:0] rest;
        logic [16:0] run_sum;
        logic [31:0] lhs;
        logic [31:0] rhs;
        bit          found;
        int          i;
        res = '0;
        case (t_op'(it.operation))
            OP_ADD: begin
                if (rx_count >= MAX_RX) begin
                    res.status = ST_FULL;
                end else begin
                    if (it.use_even_share || it.link_probability > Q_ONE)
                        share = 17'(32'(Q_ONE) / (32'(rx_count) + 32'd1));
                    else
                        share = it.link_probability;
                    keep = Q_ONE - share;
                    for (i = 0; i < MAX_RX; i++) begin
                        if (i < rx_count)
                            rx_prob[i] = clip_one((34'(rx_prob[i]) * 34'(keep)) >> 16);
                    end
                    rx_prob[rx_count] = share;
                    rx_count = rx_count + 5'd1;
                    res.status = ST_OK;
                end
            end
            OP_REMOVE: begin
                if (rx_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    rx_count = rx_count - 5'd1;
                    gone = rx_prob[rx_count];
                    rx_prob[rx_count] = '0;
                    if (gone >= Q_ONE) begin
                        // Nothing left to renormalize against.
                        res.status = ST_ONE;
                    end else begin
                        rest = Q_ONE - gone;
                        for (i = 0; i < MAX_RX; i++) begin
                            if (i < rx_count)
                                rx_prob[i] = clip_one((34'(rx_prob[i]) << 16) / 34'(rest));
                        end
                        res.status = ST_OK;
                    end
                end
            end
            OP_ROUTE: begin
                if (rx_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    run_sum = '0;
                    found   = 1'b0;
                    lhs     = 32'(it.random_draw) * 32'(Q_ONE);
                    for (i = 0; i < MAX_RX; i++) begin
                        if (i < rx_count && !found) begin
                            run_sum = clip_one(34'(run_sum) + 34'(rx_prob[i]));
                            rhs = 32'(run_sum) * 32'(DRAW_SCALE);
                            if (lhs <= rhs) begin
                                found            = 1'b1;
                                res.picked       = 1'b1;
                                res.chosen_index = 4'(i);
                            end
                        end
                    end
                    res.status = ST_OK;
                end
            end
            default: res.status = ST_OK;
        endcase
        res.link_count = rx_count;
        return res;
    endfunction

    // Queues one transaction and tracks the receiver count the block should reach.
    task automatic queue_op(input t_op op, input logic [16:0] prob, input logic even,
                            input logic [6:0] draw, input bit drain);
        t_pending p;
        p.item.operation        = op;
        p.item.link_probability = prob;
        p.item.use_even_share   = even;
        p.item.random_draw      = draw;
        p.drain_first           = drain;
        pending_items.insert(pending_items.size(), p);
        n_items++;
        if (op == OP_ADD && gen_count < MAX_RX)
            gen_count++;
        else if (op == OP_REMOVE && gen_count > 0)
            gen_count--;
    endtask

    // Sender: loads the next pending transaction once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_items.size() != 0
                    && !(pending_items[0].drain_first && (i_in_valid || in_flight != 0))
                    && ($urandom_range(99) >= ((sent >= 700 && sent < 900) ? 0 : 21))) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_items[0].item;
                void'(pending_items.pop_front());
                sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, one long hold-off, one stretch always ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                taken++;
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (taken >= 500 && !held) begin
                held = 1'b1;
                hold_left = 300;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (taken >= 900 && taken < 1100) ? 1'b1
                               : ($urandom_range(99) >= 21);
            end
        end
    end

    // Monitor: checks results in order, predicts on input transactions, watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction %p", o_out_data);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.chosen_index !== want.chosen_index) begin
                        $error("chosen_index: expected %0d, got %0d",
                               want.chosen_index, o_out_data.chosen_index);
                        errors++;
                    end
                    if (o_out_data.picked !== want.picked) begin
                        $error("picked: expected %0d, got %0d", want.picked, o_out_data.picked);
                        errors++;
                    end
                    if (o_out_data.link_count !== want.link_count) begin
                        $error("link_count: expected %0d, got %0d",
                               want.link_count, o_out_data.link_count);
                        errors++;
                    end
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                        errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready)
                expected_results.insert(expected_results.size(), predict_router(i_in_data));
            in_flight <= in_flight + int'(i_in_valid && o_in_ready)
                         - int'(o_out_valid && i_out_ready);
            accepted_in <= accepted_in + int'(i_in_valid && o_in_ready);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int          target;
        int          r;
        t_op         op;
        logic [16:0] prob;
        logic [6:0]  draw;

        for (int k = 0; k < MAX_RX; k++)
            rx_prob[k] = '0;
        rx_count = '0;

        // Directed part: empty table, certain pick, unreachable draws, last entry.
        queue_op(OP_ROUTE,  17'd0,      1'b0, 7'd0,   1'b0);
        queue_op(OP_REMOVE, 17'd0,      1'b0, 7'd0,   1'b0);
        queue_op(OP_NOP,    17'h1FFFF,  1'b1, 7'd127, 1'b0);
        queue_op(OP_ADD,    Q_ONE,      1'b0, 7'd0,   1'b0);
        queue_op(OP_ROUTE,  17'd0,      1'b0, 7'd99,  1'b0);
        queue_op(OP_ROUTE,  17'd0,      1'b0, 7'd127, 1'b0);
        queue_op(OP_ADD,    17'd5,      1'b1, 7'd0,   1'b0);
        queue_op(OP_ROUTE,  17'd0,      1'b0, 7'd99,  1'b0);
        queue_op(OP_ROUTE,  17'd0,      1'b0, 7'd0,   1'b0);
        queue_op(OP_ADD,    17'h1FFFF,  1'b0, 7'd0,   1'b0);
        queue_op(OP_ADD,    17'd0,      1'b0, 7'd0,   1'b0);
        queue_op(OP_ROUTE,  17'd0,      1'b0, 7'd100, 1'b0);
        queue_op(OP_ROUTE,  17'd0,      1'b0, 7'd50,  1'b0);
        queue_op(OP_REMOVE, 17'd0,      1'b0, 7'd0,   1'b0);
        queue_op(OP_REMOVE, 17'd0,      1'b0, 7'd0,   1'b0);
        queue_op(OP_ADD,    Q_ONE,      1'b0, 7'd0,   1'b0);
        // Removing an entry of exactly one leaves the others untouched.
        queue_op(OP_REMOVE, 17'd0,      1'b0, 7'd0,   1'b0);
        queue_op(OP_REMOVE, 17'd0,      1'b0, 7'd0,   1'b0);
        queue_op(OP_REMOVE, 17'd0,      1'b0, 7'd0,   1'b0);
        queue_op(OP_ADD,    17'd1,      1'b0, 7'd0,   1'b0);
        queue_op(OP_ROUTE,  17'd0,      1'b0, 7'd1,   1'b0);
        queue_op(OP_REMOVE, 17'd0,      1'b0, 7'd0,   1'b0);

        // Random part: the table size drifts toward a target that changes now and then.
        target = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                target = ($urandom_range(3) == 0) ? MAX_RX : $urandom_range(MAX_RX);
            r = $urandom_range(99);
            if (r < 5)
                op = OP_NOP;
            else if (r < 50)
                op = OP_ROUTE;
            else if (r < 60)
                op = $urandom_range(1) ? OP_ADD : OP_REMOVE;
            else if (gen_count < target)
                op = OP_ADD;
            else if (gen_count > target)
                op = OP_REMOVE;
            else
                op = $urandom_range(1) ? OP_ADD : OP_REMOVE;
            case ($urandom_range(9))
                0:       prob = Q_ONE;
                1:       prob = '0;
                2:       prob = 17'($urandom_range(131071, 65537));
                3:       prob = 17'($urandom_range(2047));
                4:       prob = Q_ONE - 17'($urandom_range(2047));
                default: prob = 17'($urandom_range(65536));
            endcase
            draw = ($urandom_range(99) < 85) ? 7'($urandom_range(99))
                                              : 7'($urandom_range(127, 100));
            queue_op(op, prob, ($urandom_range(3) == 0), draw, (n == 0 || n == 1300));
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (accepted_in != n_items || in_flight != 0);
        repeat (50) @(posedge i_clk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (expected_results.size() != 0)
                $error("%0d expected results never arrived", expected_results.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/wrr_pkg.sv
design/wrr_div.sv
design/wrr_datapath.sv
design/wrr_ctrl.sv
design/weighted_random_router_core.sv
tb/weighted_random_router_core_tb.sv
